// File: hw/rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;

    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_X     = 2'd1;
    localparam logic [1:0] CASE_Y     = 2'd2;
    localparam logic [1:0] CASE_Z     = 2'd3;

    typedef struct packed {
        logic signed [15:0] elem_00;
        logic signed [15:0] elem_01;
        logic signed [15:0] elem_02;
        logic signed [15:0] elem_10;
        logic signed [15:0] elem_11;
        logic signed [15:0] elem_12;
        logic signed [15:0] elem_20;
        logic signed [15:0] elem_21;
        logic signed [15:0] elem_22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [1:0]         case_taken;
        logic               invalid;
    } rmq_out_t;

endpackage

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter.
// A request on in_data (valid/ready) carries the nine Q1.14 entries of a
// 3x3 rotation matrix; one result on out_data (valid/ready) carries the
// quaternion x, y, z, w, the case taken and the invalid flag, in order.
// The datapath is a fixed pipeline: an input stage that forms the radicand
// and numerators, one stage per root bit of the square root, one setup
// stage, sixteen stages of four parallel restoring dividers, and an output
// register. One request is taken every cycle unless the receiver stalls.
// The whole pipeline advances when the output register is empty or being
// read, so when the receiver stalls, in_ready drops and every stage holds;
// nothing is lost or repeated. Reset clears the valid bits of all stages
// and the output register; data registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rmq_pkg::rmq_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rmq_pkg::rmq_out_t out_data
);

    localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int VW0 = RW - 1 + FRAC_BITS + 2;
    localparam int VW  = VW0 + (VW0 % 2);
    localparam int SW  = VW / 2;
    localparam int DW  = FRAC_BITS + 18;
    localparam int CW  = ((SW + 16) > DW) ? (SW + 16) : DW;
    localparam int NW  = 18;
    localparam int QB  = 16;
    localparam int NST = SW + QB + 2;

    typedef struct packed {
        logic [1:0]               sel;
        logic [1:0]               lead;
        logic                     inv;
        logic [3:0][NW-1:0]       num;
        logic [VW-1:0]            v;
        logic [SW:0]              rem;
        logic [SW-1:0]            s;
        logic [3:0][SW-1:0]       drem;
        logic [3:0][QB-1:0]       dlow;
        logic [3:0][QB-1:0]       quo;
        logic [3:0]               ovf;
        logic [3:0]               neg;
    } stage_t;

    stage_t             pipe_reg  [NST];
    stage_t             pipe_next [NST];
    logic [NST-1:0]     vld_reg;
    logic               out_valid_reg;
    rmq_pkg::rmq_out_t  out_data_reg;
    rmq_pkg::rmq_out_t  out_data_next;
    logic               adv;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Input stage: case selection, radicand and numerators.
    always_comb
    begin
        logic signed [RW-1:0] e00, e11, e22, one, rad;
        logic signed [NW-1:0] a01, a02, a10, a12, a20, a21;
        stage_t n;
        e00 = RW'(in_data.elem_00);
        e11 = RW'(in_data.elem_11);
        e22 = RW'(in_data.elem_22);
        a01 = NW'(in_data.elem_01);
        a02 = NW'(in_data.elem_02);
        a10 = NW'(in_data.elem_10);
        a12 = NW'(in_data.elem_12);
        a20 = NW'(in_data.elem_20);
        a21 = NW'(in_data.elem_21);
        one = RW'(1) <<< FRAC_BITS;
        n = '0;
        n.num[0] = a12 - a21;
        n.num[1] = a20 - a02;
        n.num[2] = a01 - a10;
        rad = one + e00 + e11 + e22;
        if (rad > 0)
        begin
            n.sel  = rmq_pkg::CASE_TRACE;
            n.lead = 2'd3;
        end
        else if (in_data.elem_00 > in_data.elem_11 && in_data.elem_00 > in_data.elem_22)
        begin
            n.sel    = rmq_pkg::CASE_X;
            n.lead   = 2'd0;
            rad      = one + e00 - e11 - e22;
            n.num[3] = a12 - a21;
            n.num[1] = a10 + a01;
            n.num[2] = a02 + a20;
        end
        else if (in_data.elem_11 > in_data.elem_22)
        begin
            n.sel    = rmq_pkg::CASE_Y;
            n.lead   = 2'd1;
            rad      = one + e11 - e00 - e22;
            n.num[3] = a20 - a02;
            n.num[0] = a10 + a01;
            n.num[2] = a21 + a12;
        end
        else
        begin
            n.sel    = rmq_pkg::CASE_Z;
            n.lead   = 2'd2;
            rad      = one + e22 - e00 - e11;
            n.num[3] = a01 - a10;
            n.num[0] = a20 + a02;
            n.num[1] = a21 + a12;
        end
        n.inv = (rad <= 0);
        n.v   = n.inv ? '0 : (VW'(rad[RW-2:0]) << (FRAC_BITS + 2));
        pipe_next[0] = n;
    end

    // Square root: one root bit per stage.
    for (genvar k = 1; k <= SW; k++)
    begin : g_sqrt
        always_comb
        begin
            logic [SW+2:0] rem_t;
            logic [SW+2:0] trial;
            logic [SW+2:0] diff;
            stage_t n;
            n     = pipe_reg[k-1];
            rem_t = {pipe_reg[k-1].rem, pipe_reg[k-1].v[VW-1 -: 2]};
            trial = {1'b0, pipe_reg[k-1].s, 2'b01};
            diff  = rem_t - trial;
            if (rem_t >= trial)
            begin
                n.rem = diff[SW:0];
                n.s   = {pipe_reg[k-1].s[SW-2:0], 1'b1};
            end
            else
            begin
                n.rem = rem_t[SW:0];
                n.s   = {pipe_reg[k-1].s[SW-2:0], 1'b0};
            end
            n.v = pipe_reg[k-1].v << 2;
            pipe_next[k] = n;
        end
    end

    // Divider setup: dividend with half-divisor rounding and overflow check.
    always_comb
    begin
        logic [NW-1:0] mag;
        logic [CW-1:0] dvd;
        logic [CW-1:0] dsh;
        stage_t n;
        n = pipe_reg[SW];
        for (int i = 0; i < 4; i++)
        begin
            n.neg[i]  = pipe_reg[SW].num[i][NW-1];
            mag       = n.neg[i] ? (NW'(0) - pipe_reg[SW].num[i]) : pipe_reg[SW].num[i];
            dvd       = (CW'(mag) << FRAC_BITS) + CW'(pipe_reg[SW].s >> 1);
            n.ovf[i]  = (dvd >= (CW'(pipe_reg[SW].s) << QB));
            dsh       = dvd >> QB;
            n.drem[i] = dsh[SW-1:0];
            n.dlow[i] = dvd[QB-1:0];
            n.quo[i]  = '0;
        end
        pipe_next[SW+1] = n;
    end

    // Restoring division: one quotient bit per stage in each of four lanes.
    for (genvar k = SW + 2; k < NST; k++)
    begin : g_div
        always_comb
        begin
            logic [SW:0] rem_t;
            logic        qb;
            stage_t n;
            n = pipe_reg[k-1];
            for (int i = 0; i < 4; i++)
            begin
                rem_t = {pipe_reg[k-1].drem[i], pipe_reg[k-1].dlow[i][QB-1]};
                qb    = (rem_t >= {1'b0, pipe_reg[k-1].s});
                if (qb)
                begin
                    rem_t = rem_t - {1'b0, pipe_reg[k-1].s};
                end
                n.drem[i] = rem_t[SW-1:0];
                n.dlow[i] = pipe_reg[k-1].dlow[i] << 1;
                n.quo[i]  = {pipe_reg[k-1].quo[i][QB-2:0], qb};
            end
            pipe_next[k] = n;
        end
    end

    // Output: rounding of the leading term, saturation and case mapping.
    always_comb
    begin
        logic [SW:0]        lv;
        logic signed [15:0] lead16;
        logic signed [15:0] q [4];
        stage_t p;
        p  = pipe_reg[NST-1];
        lv = ({1'b0, p.s} + (SW+1)'(2)) >> 2;
        lead16 = (lv > (SW+1)'(32767)) ? 16'sh7FFF : lv[15:0];
        for (int i = 0; i < 4; i++)
        begin
            if (p.neg[i])
            begin
                q[i] = (p.ovf[i] || p.quo[i] > 16'd32768) ? 16'sh8000 : (16'd0 - p.quo[i]);
            end
            else
            begin
                q[i] = (p.ovf[i] || p.quo[i][15]) ? 16'sh7FFF : p.quo[i];
            end
            if (p.lead == 2'(i))
            begin
                q[i] = lead16;
            end
            if (p.inv)
            begin
                q[i] = '0;
            end
        end
        out_data_next.quat_x     = q[0];
        out_data_next.quat_y     = q[1];
        out_data_next.quat_z     = q[2];
        out_data_next.quat_w     = q[3];
        out_data_next.case_taken = p.sel;
        out_data_next.invalid    = p.inv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NST-2:0], in_valid};
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
            out_data_reg <= out_data_next;
        end
    end

    // A stalled output must freeze the pipeline input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while output stalled");

    // An invalid result carries zero components.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.invalid) |->
        (out_data.quat_x == 0 && out_data.quat_y == 0 &&
         out_data.quat_z == 0 && out_data.quat_w == 0))
        else $error("invalid result with nonzero components");

    // The trace path always has a positive radicand.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.case_taken == rmq_pkg::CASE_TRACE) |-> !out_data.invalid)
        else $error("trace path flagged invalid");

    // A held result keeps its payload while the pipeline is frozen.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(out_valid && !out_ready) && $past(rst_n)) |-> $stable(out_data))
        else $error("stalled result changed");

endmodule

// File: tb/sv/rotation_matrix_to_quaternion_tb.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;

    localparam int FRAC = rmq_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 40;
    localparam int RANDOM_REQUESTS = 1880;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        rmq_pkg::rmq_in_t  req;
        logic              known;
        rmq_pkg::rmq_out_t res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    rmq_pkg::rmq_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    rmq_pkg::rmq_out_t out_data;

    rmq_pkg::rmq_out_t quat_pending[$];
    int       error_count;
    int       sent_count;
    int       recv_count;
    int       invalid_count;
    int       case_seen[4];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off_cycles;
    longint   cycle_count;

    rotation_matrix_to_quaternion dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Numerator over scale, rounded to nearest with ties away from zero.
    function automatic longint scaled_quotient(longint n, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = ((mag << FRAC) + (s >> 1)) / s;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic rmq_pkg::rmq_out_t predict_quaternion(rmq_pkg::rmq_in_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint nx, ny, nz, nw, rad;
        longint unsigned s;
        int lead;
        longint comp[4];
        rmq_pkg::rmq_out_t r;
        a00 = m.elem_00; a01 = m.elem_01; a02 = m.elem_02;
        a10 = m.elem_10; a11 = m.elem_11; a12 = m.elem_12;
        a20 = m.elem_20; a21 = m.elem_21; a22 = m.elem_22;
        nx = a12 - a21;
        ny = a20 - a02;
        nz = a01 - a10;
        nw = 0;
        rad = (longint'(1) << FRAC) + a00 + a11 + a22;
        r = '0;
        if (rad > 0)
        begin
            r.case_taken = rmq_pkg::CASE_TRACE;
            lead = 3;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            r.case_taken = rmq_pkg::CASE_X;
            lead = 0;
            rad = (longint'(1) << FRAC) + a00 - a11 - a22;
            nw = nx;
            ny = a10 + a01;
            nz = a02 + a20;
        end
        else if (a11 > a22)
        begin
            r.case_taken = rmq_pkg::CASE_Y;
            lead = 1;
            rad = (longint'(1) << FRAC) + a11 - a00 - a22;
            nw = ny;
            nx = a10 + a01;
            nz = a21 + a12;
        end
        else
        begin
            r.case_taken = rmq_pkg::CASE_Z;
            lead = 2;
            rad = (longint'(1) << FRAC) + a22 - a00 - a11;
            nw = nz;
            nx = a20 + a02;
            ny = a21 + a12;
        end
        if (rad <= 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        s = int_sqrt(longint'(rad) << (FRAC + 2));
        comp[0] = scaled_quotient(nx, s);
        comp[1] = scaled_quotient(ny, s);
        comp[2] = scaled_quotient(nz, s);
        comp[3] = scaled_quotient(nw, s);
        comp[lead] = longint'((s + 2) >> 2);
        r.quat_x = clamp16(comp[0]);
        r.quat_y = clamp16(comp[1]);
        r.quat_z = clamp16(comp[2]);
        r.quat_w = clamp16(comp[3]);
        return r;
    endfunction

    function automatic rmq_pkg::rmq_in_t make_matrix(
        int e00, int e01, int e02, int e10, int e11, int e12, int e20, int e21, int e22);
        rmq_pkg::rmq_in_t m;
        m.elem_00 = 16'(e00); m.elem_01 = 16'(e01); m.elem_02 = 16'(e02);
        m.elem_10 = 16'(e10); m.elem_11 = 16'(e11); m.elem_12 = 16'(e12);
        m.elem_20 = 16'(e20); m.elem_21 = 16'(e21); m.elem_22 = 16'(e22);
        return m;
    endfunction

    function automatic rmq_pkg::rmq_out_t make_quat(int x, int y, int z, int w,
                                                    logic [1:0] c, logic inv);
        rmq_pkg::rmq_out_t r;
        r.quat_x = 16'(x); r.quat_y = 16'(y); r.quat_z = 16'(z); r.quat_w = 16'(w);
        r.case_taken = c;
        r.invalid = inv;
        return r;
    endfunction

    function automatic int rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    // Mostly near-rotation matrices biased toward each case, plus raw noise.
    function automatic rmq_pkg::rmq_in_t random_matrix();
        int d[3];
        int off[6];
        int pick;
        for (int i = 0; i < 6; i++)
            off[i] = int'($urandom_range(0, 32768)) - 16384;
        pick = $urandom_range(0, 9);
        if (pick >= 8)
            return make_matrix(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                               rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                               rand_elem());
        for (int i = 0; i < 3; i++)
            d[i] = -int'($urandom_range(0, 16384));
        if (pick < 2)
            for (int i = 0; i < 3; i++)
                d[i] = int'($urandom_range(0, 32767)) - 16384;
        else if (pick < 8)
            d[(pick - 2) % 3] = $urandom_range(0, 16384);
        return make_matrix(d[0], off[0], off[1], off[2], d[1], off[3], off[4], off[5], d[2]);
    endfunction

    task automatic send_request(rmq_pkg::rmq_in_t m, logic known, rmq_pkg::rmq_out_t res);
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= m;
        quat_pending.push_back(known ? res : predict_quaternion(m));
        if (known && predict_quaternion(m) !== res)
        begin
            $error("table row disagrees with predictor for matrix %h", m);
            error_count++;
        end
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (quat_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rmq_pkg::rmq_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            recv_count++;
            if (quat_pending.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                error_count++;
            end
            else
            begin
                want = quat_pending.pop_front();
                if (out_data.quat_x !== want.quat_x)
                begin
                    $error("quat_x expected %0d got %0d", want.quat_x, out_data.quat_x);
                    error_count++;
                end
                if (out_data.quat_y !== want.quat_y)
                begin
                    $error("quat_y expected %0d got %0d", want.quat_y, out_data.quat_y);
                    error_count++;
                end
                if (out_data.quat_z !== want.quat_z)
                begin
                    $error("quat_z expected %0d got %0d", want.quat_z, out_data.quat_z);
                    error_count++;
                end
                if (out_data.quat_w !== want.quat_w)
                begin
                    $error("quat_w expected %0d got %0d", want.quat_w, out_data.quat_w);
                    error_count++;
                end
                if (out_data.case_taken !== want.case_taken)
                begin
                    $error("case_taken expected %0d got %0d",
                           want.case_taken, out_data.case_taken);
                    error_count++;
                end
                if (out_data.invalid !== want.invalid)
                begin
                    $error("invalid expected %0d got %0d", want.invalid, out_data.invalid);
                    error_count++;
                end
                if (want.invalid)
                    invalid_count++;
                case_seen[want.case_taken]++;
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        rmq_pkg::rmq_out_t none;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        error_count = 0;
        sent_count = 0;
        recv_count = 0;
        invalid_count = 0;
        case_seen = '{0, 0, 0, 0};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        cycle_count = 0;

        // Identity gives w = 1; the half-turn cases put 1 in the leading slot.
        rows.push_back('{make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
                         make_quat(0, 0, 0, 16384, rmq_pkg::CASE_TRACE, 1'b0)});
        rows.push_back('{make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1,
                         make_quat(16384, 0, 0, 0, rmq_pkg::CASE_X, 1'b0)});
        rows.push_back('{make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b1,
                         make_quat(0, 16384, 0, 0, rmq_pkg::CASE_Y, 1'b0)});
        rows.push_back('{make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b1,
                         make_quat(0, 0, 16384, 0, rmq_pkg::CASE_Z, 1'b0)});
        // All zero: trace radicand is one, w = 1/2.
        rows.push_back('{make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         make_quat(0, 0, 0, 8192, rmq_pkg::CASE_TRACE, 1'b0)});
        // Negative diagonals and ties that leave the trace path for a diagonal case.
        rows.push_back('{make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, none});
        rows.push_back('{make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, none});
        rows.push_back('{make_matrix(-8192, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, none});
        rows.push_back('{make_matrix(-16384, 0, 0, 0, -8192, 0, 0, 0, -16384), 1'b0, none});
        // Extremes and saturating quotients, checked by the predictor.
        rows.push_back('{make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767), 1'b0, none});
        rows.push_back('{make_matrix(-32768, 32767, -32768, -32768, -32768, 32767,
                                     32767, -32768, 16384), 1'b0, none});
        rows.push_back('{make_matrix(-16383, 32767, -32768, -32768, -16384, 32767,
                                     32767, -32768, -1), 1'b0, none});
        rows.push_back('{make_matrix(-1, 32767, 32767, 32767, -32768, -32768, 32767,
                                     -32768, -32768), 1'b0, none});
        rows.push_back('{make_matrix(-32768, -32768, 32767, 32767, -1, 32767, -32768,
                                     32767, -32768), 1'b0, none});
        rows.push_back('{make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, 0), 1'b0, none});
        rows.push_back('{make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384), 1'b0, none});
        rows.push_back('{make_matrix(-5461, 21845, -10923, 1, -5462, 7, 255, -256, -5461),
                         1'b0, none});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_request(rows[i].req, rows[i].known, rows[i].res);
        drain_pipeline();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 10;
                               hold_off_cycles = 300; end
            endcase
            for (int n = 0; n < RANDOM_REQUESTS / 5; n++)
                send_request(random_matrix(), 1'b0, none);
            drain_pipeline();
        end

        $display("Sent %0d matrices, got %0d quaternions (%0d invalid).",
                 sent_count, recv_count, invalid_count);
        $display("Cases: trace %0d, x %0d, y %0d, z %0d.",
                 case_seen[0], case_seen[1], case_seen[2], case_seen[3]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: rotation_matrix_to_quaternion.f
hw/rtl/rmq_pkg.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
